// File: hdl/upd_pkg.sv
// Package for the URL percent decoder: character constants, the packet type
// that carries up to three result bytes from front to back, and hex helpers.
// No dependencies.
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CHAR_PCT     = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] HEX_ALPHA    = 8'h40;
    localparam logic [7:0] HEX_NIBBLE   = 8'h0F;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int unsigned QDEPTH      = 2;
    localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic                        no_byte;
        logic                        str_end;
    } pkt_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = ((c & HEX_ALPHA) != 8'h00) ? ((c & HEX_NIBBLE) + 8'd9) : (c & HEX_NIBBLE);
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/upd_front.sv
// Front end of the URL percent decoder: accepts input bytes, tracks the
// pending escape and pushes a packet for each input byte with a result.
// Depends on upd_pkg.
`default_nettype none

module upd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               push_valid,
    input  wire logic          push_ready,
    output upd_pkg::pkt_t      push_pkt
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [7:0]                    held_reg, held_next;
    upd_pkg::pkt_t                 pkt;
    logic [upd_pkg::CNT_W-1:0]     n;
    logic                          do_plain;
    logic [7:0]                    dec;
    logic                          acc;

    always_comb
    begin
        pkt        = '0;
        n          = '0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        do_plain   = 1'b0;
        dec        = {upd_pkg::hex_value(held_reg), upd_pkg::hex_value(in_byte)};
        case (phase_reg)
            PH_PCT:
            begin
                if (upd_pkg::is_hex(in_byte))
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    pkt.bytes[n] = upd_pkg::CHAR_PCT;
                    n            = n + 1'b1;
                    do_plain     = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (upd_pkg::is_hex(in_byte))
                begin
                    if (dec != 8'h00)
                    begin
                        pkt.bytes[n] = dec;
                        n            = n + 1'b1;
                    end
                end
                else
                begin
                    pkt.bytes[n] = upd_pkg::CHAR_PCT;
                    n            = n + 1'b1;
                    pkt.bytes[n] = held_reg;
                    n            = n + 1'b1;
                    do_plain     = 1'b1;
                end
            end
            default:
            begin
                do_plain = 1'b1;
            end
        endcase
        if (do_plain)
        begin
            if (in_byte == upd_pkg::CHAR_PCT)
            begin
                phase_next = PH_PCT;
            end
            else
            begin
                pkt.bytes[n] = (in_byte == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : in_byte;
                n            = n + 1'b1;
            end
        end
        if (in_last)
        begin
            if (phase_next == PH_PCT)
            begin
                pkt.bytes[n] = upd_pkg::CHAR_PCT;
                n            = n + 1'b1;
            end
            else if (phase_next == PH_DIGIT)
            begin
                pkt.bytes[n] = upd_pkg::CHAR_PCT;
                n            = n + 1'b1;
                pkt.bytes[n] = held_next;
                n            = n + 1'b1;
            end
            phase_next = PH_IDLE;
            if (n == '0)
            begin
                n           = upd_pkg::CNT_W'(1);
                pkt.no_byte = 1'b1;
            end
            pkt.str_end = 1'b1;
        end
        pkt.cnt = n;
    end

    assign in_ready   = push_ready;
    assign acc        = in_valid && in_ready;
    assign push_valid = acc && (n != '0);
    assign push_pkt   = pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/upd_queue.sv
// Short packet queue between the front and back ends of the URL percent
// decoder, so that either side can stall on its own. Depends on upd_pkg.
`default_nettype none

module upd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire upd_pkg::pkt_t push_pkt,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output upd_pkg::pkt_t      pop_pkt
);

    upd_pkg::pkt_t              mem_reg [upd_pkg::QDEPTH];
    logic [upd_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [upd_pkg::QCNT_W-1:0] cnt_reg;
    logic                       do_push, do_pop;

    assign push_ready = (cnt_reg != upd_pkg::QCNT_W'(upd_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_pkt    = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == upd_pkg::QPTR_W'(upd_pkg::QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == upd_pkg::QPTR_W'(upd_pkg::QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_pkt;
        end
    end

endmodule

`default_nettype wire

// File: hdl/upd_back.sv
// Back end of the URL percent decoder: takes packets from the queue and
// sends their bytes one per word through a registered output. Depends on upd_pkg.
`default_nettype none

module upd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire upd_pkg::pkt_t pop_pkt,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               run_last,
    output logic               string_end
);

    upd_pkg::pkt_t             cur_reg;
    logic                      cur_valid_reg;
    logic [upd_pkg::CNT_W-1:0] idx_reg;
    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      byte_valid_reg, run_last_reg, string_end_reg;
    logic                      load_out, last_one, take;

    assign load_out  = cur_valid_reg && (!out_valid_reg || out_ready);
    assign last_one  = ((idx_reg + 1'b1) == cur_reg.cnt);
    assign pop_ready = !cur_valid_reg || (load_out && last_one);
    assign take      = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (load_out && last_one)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (load_out)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= pop_pkt;
        end
        if (load_out)
        begin
            out_byte_reg   <= cur_reg.bytes[idx_reg];
            byte_valid_reg <= !cur_reg.no_byte;
            run_last_reg   <= last_one;
            string_end_reg <= cur_reg.str_end && last_one;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign run_last   = run_last_reg;
    assign string_end = string_end_reg;

endmodule

`default_nettype wire

// File: hdl/url_percent_decoder_top.sv
// Top level of the streaming URL percent decoder.
// Instantiates upd_front, upd_queue and upd_back; depends on upd_pkg.
//
// Input words carry one encoded byte and a flag on the last byte of a string.
// Each input word causes zero to three output words. A '%' with two hex digits
// becomes one byte (a zero result is dropped), '+' becomes a space, a broken
// escape goes out literally, and the last byte flushes any pending escape.
// The final word of a string carries string_end; it may have byte_valid low
// when the last input byte gave no result. run_last marks the last output word
// caused by one input word.
// The first output word of an input passes through the packet queue, the back
// end's packet register and its output register before it is presented.
// The front end takes one input word per cycle as long as the two-entry packet
// queue has room; the back end sends one output word per cycle when out_ready
// is high, so inputs that make two or three words can fill the queue.
// When the receiver stalls, the output register holds its word and the queue
// fills, after which in_ready falls. Reset clears the escape state, the queue
// and the output valid; no words are pending afterwards.
`default_nettype none

module url_percent_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            string_end
);

    logic          push_valid, push_ready, pop_valid, pop_ready;
    upd_pkg::pkt_t push_pkt, pop_pkt;

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pkt   (push_pkt)
    );

    upd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pkt   (push_pkt),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_pkt    (pop_pkt)
    );

    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_pkt    (pop_pkt),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

`default_nettype wire

// File: hdl/upd_checker.sv
// Port-level checker for the URL percent decoder top level, with the bind
// that attaches it. Depends only on the ports of url_percent_decoder_top.
`default_nettype none

module upd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       run_last,
    input wire logic       string_end
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("Output valid during reset.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(run_last) && $stable(string_end)))
        else $error("Stalled output word changed.");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_end) |-> run_last)
        else $error("String end without run end.");

    a_empty_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (string_end && (out_byte == 8'h00)))
        else $error("Empty word outside string end.");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end)
);

`default_nettype wire

// File: tb/sv/url_percent_decoder_checker.sv
// Checker for url_percent_decoder_top. It watches both channels, decodes every accepted
// input word in its own copy of the escape state, and compares each output word in order.
// Depends on upd_pkg for the character constants.
module url_percent_decoder_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       byte_valid,
    input  wire logic       run_last,
    input  wire logic       string_end,
    output int              errors,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    typedef struct {
        logic [7:0] data;
        logic       data_ok;
        logic       word_end;
        logic       str_end;
    } decoded_word_t;

    decoded_word_t decoded_q[$];
    decoded_word_t step_words[$];
    decoded_word_t head;
    logic [1:0]    esc_state;
    logic [7:0]    first_digit;

    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] digit_value(logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    task automatic add_word(logic [7:0] d, logic ok);
        step_words.push_back('{d, ok, 1'b0, 1'b0});
    endtask

    task automatic take_plain(logic [7:0] b);
        if (b == upd_pkg::CHAR_PCT)
        begin
            esc_state = ESC_PCT;
        end
        else
        begin
            esc_state = ESC_NONE;
            add_word((b == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : b, 1'b1);
        end
    endtask

    task automatic decode_byte(logic [7:0] b, logic closes);
        logic [7:0] value;
        step_words.delete();
        case (esc_state)
            ESC_PCT:
            begin
                if (is_hex_char(b))
                begin
                    first_digit = b;
                    esc_state   = ESC_DIGIT;
                end
                else
                begin
                    add_word(upd_pkg::CHAR_PCT, 1'b1);
                    take_plain(b);
                end
            end
            ESC_DIGIT:
            begin
                if (is_hex_char(b))
                begin
                    value     = {digit_value(first_digit), digit_value(b)};
                    esc_state = ESC_NONE;
                    if (value != 8'h00)
                    begin
                        add_word(value, 1'b1);
                    end
                end
                else
                begin
                    add_word(upd_pkg::CHAR_PCT, 1'b1);
                    add_word(first_digit, 1'b1);
                    take_plain(b);
                end
            end
            default:
            begin
                take_plain(b);
            end
        endcase
        if (closes)
        begin
            if (esc_state == ESC_PCT)
            begin
                add_word(upd_pkg::CHAR_PCT, 1'b1);
            end
            else if (esc_state == ESC_DIGIT)
            begin
                add_word(upd_pkg::CHAR_PCT, 1'b1);
                add_word(first_digit, 1'b1);
            end
            esc_state = ESC_NONE;
            if (step_words.size() == 0)
            begin
                add_word(8'h00, 1'b0);
            end
            step_words[step_words.size()-1].str_end = 1'b1;
        end
        if (step_words.size() > 0)
        begin
            step_words[step_words.size()-1].word_end = 1'b1;
        end
        foreach (step_words[i])
        begin
            decoded_q.push_back(step_words[i]);
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            esc_state   = ESC_NONE;
            first_digit = 8'h00;
            decoded_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected output word: out_byte %0h", out_byte);
                    errors++;
                end
                else
                begin
                    head = decoded_q.pop_front();
                    check_field("out_byte", head.data, out_byte);
                    check_field("byte_valid", {7'd0, head.data_ok}, {7'd0, byte_valid});
                    check_field("run_last", {7'd0, head.word_end}, {7'd0, run_last});
                    check_field("string_end", {7'd0, head.str_end}, {7'd0, string_end});
                end
            end
            if (in_valid && in_ready)
            begin
                decode_byte(in_byte, in_last);
            end
        end
        pending = decoded_q.size();
    end

endmodule

// File: tb/sv/tb_url_percent_decoder_top.sv
// Testbench top for url_percent_decoder_top: clock, reset, encoded strings with random
// idle gaps on the input and stalls on the output. Checking is done by
// url_percent_decoder_checker; depends on upd_pkg.
module tb_url_percent_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
    int         errors;
    int         pending;
    int         words_sent = 0;
    bit         gaps_on = 1'b1;

    always #10 clk = ~clk;

    url_percent_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

    url_percent_decoder_checker decode_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end),
        .errors     (errors),
        .pending    (pending)
    );

    task automatic send_word(logic [7:0] b, logic closes);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= closes;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s, bit closes);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], closes && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    task automatic send_random_string();
        logic [7:0] text[$];
        int         kind;
        repeat ($urandom_range(1, 8))
        begin
            kind = $urandom_range(0, 20);
            if (kind == 0)
            begin
                text.push_back(upd_pkg::CHAR_PCT);
                text.push_back(8'h30);
                text.push_back(8'h30);
            end
            else if (kind == 1)
            begin
                text.push_back(upd_pkg::CHAR_PCT);
                text.push_back($urandom_range(0, 1) ? 8'h46 : 8'h66);
                text.push_back($urandom_range(0, 1) ? 8'h46 : 8'h66);
            end
            else if (kind <= 7)
            begin
                text.push_back(upd_pkg::CHAR_PCT);
                text.push_back(rand_hex());
                text.push_back(rand_hex());
            end
            else if (kind <= 9)
            begin
                text.push_back(upd_pkg::CHAR_PLUS);
            end
            else if (kind <= 14)
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind <= 16)
            begin
                text.push_back(upd_pkg::CHAR_PCT);
                text.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind <= 18)
            begin
                text.push_back(upd_pkg::CHAR_PCT);
                text.push_back(rand_hex());
                text.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind == 19)
            begin
                text.push_back(upd_pkg::CHAR_PCT);
            end
            else
            begin
                text.push_back(upd_pkg::CHAR_PCT);
                text.push_back(rand_hex());
            end
        end
        foreach (text[i])
        begin
            send_word(text[i], i == text.size() - 1);
        end
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("a+", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("%41%ff%00", 1'b0);
        send_text("%G%4z", 1'b0);
        send_text("%4%", 1'b1);
        send_text("%00", 1'b1);
        send_text("%", 1'b1);

        while (words_sent < 240)
        begin
            if (words_sent > 185)
            begin
                gaps_on = 1'b0;
            end
            send_random_string();
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_url_percent_decoder_top passed");
        end
        else
        begin
            $display("tb_url_percent_decoder_top failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_url_percent_decoder_top failed");
        $finish;
    end

endmodule

// File: url_percent_decoder_top.f
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder_top.sv
hdl/upd_checker.sv
tb/sv/url_percent_decoder_checker.sv
tb/sv/tb_url_percent_decoder_top.sv
